@@ hw/rtl/binomial_mod_prime_engine_core_macros.svh @@
// Assertion macros used by the checker file of the binomial engine.
// Depends on nothing; include by bare file name.
`ifndef BINOMIAL_MOD_PRIME_ENGINE_CORE_MACROS_SVH
`define BINOMIAL_MOD_PRIME_ENGINE_CORE_MACROS_SVH

// Same-cycle implication.
`define BMPE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define BMPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/bmpe_pkg.sv @@
// Shared constants for the binomial engine.
// Depends on nothing.
`default_nettype none
package bmpe_pkg;
  localparam int unsigned VAL_W           = 31;
  localparam int unsigned N_W             = 12;
  localparam int unsigned R_W             = 13;
  localparam int unsigned MAX_ENTRIES_DEF = 4096;
  localparam logic [VAL_W-1:0] MOD_RESET   = 31'd1000000007;
  localparam logic [N_W-1:0]   LIMIT_RESET = 12'd4095;
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_LIMIT   = 1'b1;
endpackage
`default_nettype wire

@@ hw/rtl/bmpe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module bmpe_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/bmpe_mulmod.sv @@
// Bit-serial modular multiplier: a*b mod m, one bit of b per cycle, MSB first.
// Requires a < m. Depends on bmpe_pkg.
`default_nettype none
module bmpe_mulmod
  import bmpe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] a,
  input  wire logic [VAL_W-1:0] b,
  input  wire logic [VAL_W-1:0] m,
  output logic                  done,
  output logic      [VAL_W-1:0] result
);
  localparam int unsigned CW = $clog2(VAL_W + 1);

  logic [VAL_W-1:0] a_reg;
  logic [VAL_W-1:0] b_sh;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [VAL_W:0]   dbl;
  logic [VAL_W-1:0] dbl_red;
  logic [VAL_W:0]   sum;
  logic [VAL_W-1:0] acc_next;

  always_comb begin
    dbl     = {result, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? VAL_W'(dbl - {1'b0, m}) : VAL_W'(dbl);
    sum     = {1'b0, dbl_red} + (b_sh[VAL_W-1] ? {1'b0, a_reg} : '0);
    acc_next = (sum >= {1'b0, m}) ? VAL_W'(sum - {1'b0, m}) : VAL_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CW'(VAL_W);
        a_reg  <= a;
        b_sh   <= b;
        result <= '0;
      end else if (busy) begin
        result <= acc_next;
        b_sh   <= {b_sh[VAL_W-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/bmpe_divmod.sv @@
// Bit-serial restoring divider: m / d and m % d, one quotient bit per cycle.
// Depends on bmpe_pkg.
`default_nettype none
module bmpe_divmod
  import bmpe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] dividend,
  input  wire logic [N_W-1:0]   divisor,
  output logic                  done,
  output logic      [VAL_W-1:0] quotient,
  output logic      [N_W-1:0]   remainder
);
  localparam int unsigned CW = $clog2(VAL_W + 1);

  logic [N_W-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [N_W:0]   trial;
  logic           fits;

  always_comb begin
    trial = {remainder, quotient[VAL_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CW'(VAL_W);
        dvs       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        remainder <= fits ? N_W'(trial - {1'b0, dvs}) : N_W'(trial);
        quotient  <= {quotient[VAL_W-2:0], fits};
        cnt       <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/binomial_mod_prime_engine_core.sv @@
// Binomial coefficient C(n,r) mod a prime. The first query after reset or after any
// register write builds the factorial, inverse and inverse-factorial tables up to
// table_limit: per index from 2 on, one serial division and three serial modular
// multiplications. A query then takes three table reads and two serial multiplications
// on the shared bit-serial multiplier; queries with n above the limit or r outside 0..n
// skip the reads and multiplications.
// One query is in flight at a time; a finished result waits in the output register.
// Depends on bmpe_pkg, bmpe_ram, bmpe_mulmod, bmpe_divmod.
`default_nettype none
module binomial_mod_prime_engine_core
  import bmpe_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [11:0] total_n, [24:12] choose_r
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [30:0] binomial_value
  output logic             m_tuser,   // [0] out_of_range
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int unsigned AW  = $clog2(MAX_ENTRIES);
  localparam int unsigned TOP = MAX_ENTRIES - 1;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_BINIT = 5'd1;
  localparam logic [4:0] S_BONE  = 5'd2;
  localparam logic [4:0] S_BDIV  = 5'd3;
  localparam logic [4:0] S_BRD   = 5'd4;
  localparam logic [4:0] S_BRD2  = 5'd5;
  localparam logic [4:0] S_BMT   = 5'd6;
  localparam logic [4:0] S_BMF   = 5'd7;
  localparam logic [4:0] S_BMI   = 5'd8;
  localparam logic [4:0] S_BWR   = 5'd9;
  localparam logic [4:0] S_BDONE = 5'd10;
  localparam logic [4:0] S_QCHK  = 5'd11;
  localparam logic [4:0] S_QRD   = 5'd12;
  localparam logic [4:0] S_QRD2  = 5'd13;
  localparam logic [4:0] S_QM1   = 5'd14;
  localparam logic [4:0] S_QM2   = 5'd15;
  localparam logic [4:0] S_QOUT  = 5'd16;

  logic [4:0]       state;
  logic [VAL_W-1:0] modulus;
  logic [N_W-1:0]   table_limit;
  logic             tables_ready;
  logic [VAL_W-1:0] m_eff;
  logic [N_W-1:0]   lim;
  logic [VAL_W-1:0] one_m;
  logic             cfg_wr;

  logic [N_W-1:0]   idx;
  logic [N_W-1:0]   qn;
  logic [R_W-1:0]   qr;
  logic [VAL_W-1:0] fact_prev, ifact_prev, inv_new, fact_new, ifact_new;
  logic [VAL_W-1:0] res_val;
  logic             res_oor;

  logic             mul_start, mul_done;
  logic [VAL_W-1:0] mul_a, mul_b, mul_res;
  logic             div_start, div_done;
  logic [VAL_W-1:0] div_q;
  logic [N_W-1:0]   div_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] fact_wdata, inv_wdata, ifact_wdata;
  logic [AW-1:0]    fact_raddr, inv_raddr, ifact_raddr;
  logic [VAL_W-1:0] fact_rd, inv_rd, ifact_rd;

  assign m_eff    = (modulus == '0) ? VAL_W'(1) : modulus;
  assign lim      = (32'(table_limit) > 32'(TOP)) ? N_W'(TOP) : table_limit;
  assign one_m    = (m_eff == VAL_W'(1)) ? '0 : VAL_W'(1);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign prdata   = (paddr[2] == REG_MODULUS) ? 32'(modulus) : 32'(table_limit);

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = AW'(idx);
    fact_wdata  = fact_new;
    inv_wdata   = inv_new;
    ifact_wdata = ifact_new;
    unique case (state)
      S_BINIT: begin
        ram_we      = 1'b1;
        ram_waddr   = '0;
        fact_wdata  = one_m;
        inv_wdata   = '0;
        ifact_wdata = one_m;
      end
      S_BONE: begin
        ram_we      = 1'b1;
        ram_waddr   = AW'(1);
        fact_wdata  = one_m;
        inv_wdata   = one_m;
        ifact_wdata = one_m;
      end
      S_BWR: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  bmpe_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_fact (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(fact_wdata),
    .raddr(fact_raddr), .rdata(fact_rd)
  );
  bmpe_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_inv (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(inv_wdata),
    .raddr(inv_raddr), .rdata(inv_rd)
  );
  bmpe_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_ifact (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ifact_wdata),
    .raddr(ifact_raddr), .rdata(ifact_rd)
  );

  bmpe_mulmod u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b), .m(m_eff),
    .done(mul_done), .result(mul_res)
  );
  bmpe_divmod u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(m_eff), .divisor(idx),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      modulus      <= MOD_RESET;
      table_limit  <= LIMIT_RESET;
      tables_ready <= 1'b0;
      m_tvalid     <= 1'b0;
      mul_start    <= 1'b0;
      div_start    <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            qn    <= s_tdata[11:0];
            qr    <= s_tdata[24:12];
            state <= tables_ready ? S_QCHK : S_BINIT;
          end
        end
        S_BINIT: begin
          state <= (lim >= N_W'(1)) ? S_BONE : S_BDONE;
        end
        S_BONE: begin
          fact_prev  <= one_m;
          ifact_prev <= one_m;
          idx        <= N_W'(2);
          if (lim >= N_W'(2)) begin
            div_start <= 1'b1;
            state     <= S_BDIV;
          end else begin
            state <= S_BDONE;
          end
        end
        S_BDIV: begin
          if (div_done) begin
            inv_raddr <= AW'(div_r);
            state     <= S_BRD;
          end
        end
        S_BRD: state <= S_BRD2;
        S_BRD2: begin
          mul_start <= 1'b1;
          mul_a     <= div_q;
          mul_b     <= inv_rd;
          state     <= S_BMT;
        end
        S_BMT: begin
          if (mul_done) begin
            inv_new   <= (mul_res == '0) ? '0 : m_eff - mul_res;
            mul_start <= 1'b1;
            mul_a     <= fact_prev;
            mul_b     <= VAL_W'(idx);
            state     <= S_BMF;
          end
        end
        S_BMF: begin
          if (mul_done) begin
            fact_new  <= mul_res;
            mul_start <= 1'b1;
            mul_a     <= ifact_prev;
            mul_b     <= inv_new;
            state     <= S_BMI;
          end
        end
        S_BMI: begin
          if (mul_done) begin
            ifact_new <= mul_res;
            state     <= S_BWR;
          end
        end
        S_BWR: begin
          fact_prev  <= fact_new;
          ifact_prev <= ifact_new;
          if (idx == lim) begin
            state <= S_BDONE;
          end else begin
            idx       <= idx + 1'b1;
            div_start <= 1'b1;
            state     <= S_BDIV;
          end
        end
        S_BDONE: begin
          tables_ready <= 1'b1;
          state        <= S_QCHK;
        end
        S_QCHK: begin
          priority if (qn > lim) begin
            res_val <= '0;
            res_oor <= 1'b1;
            state   <= S_QOUT;
          end else if (qr[R_W-1] || (qr[N_W-1:0] > qn)) begin
            res_val <= '0;
            res_oor <= 1'b0;
            state   <= S_QOUT;
          end else begin
            fact_raddr  <= AW'(qn);
            ifact_raddr <= AW'(qr[N_W-1:0]);
            state       <= S_QRD;
          end
        end
        S_QRD: begin
          ifact_raddr <= AW'(qn - qr[N_W-1:0]);
          state       <= S_QRD2;
        end
        S_QRD2: begin
          mul_start <= 1'b1;
          mul_a     <= fact_rd;
          mul_b     <= ifact_rd;
          state     <= S_QM1;
        end
        S_QM1: begin
          if (mul_done) begin
            mul_start <= 1'b1;
            mul_a     <= mul_res;
            mul_b     <= ifact_rd;
            state     <= S_QM2;
          end
        end
        S_QM2: begin
          if (mul_done) begin
            res_val <= mul_res;
            res_oor <= 1'b0;
            state   <= S_QOUT;
          end
        end
        S_QOUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, res_val};
            m_tuser  <= res_oor;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_MODULUS: modulus     <= pwdata[VAL_W-1:0];
          REG_LIMIT:   table_limit <= pwdata[N_W-1:0];
          default:     modulus     <= modulus;
        endcase
        tables_ready <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/bmpe_checker.sv @@
// Port-level checker for the binomial engine, bound to the top level.
// Depends on binomial_mod_prime_engine_core_macros.svh.
`default_nettype none
`include "binomial_mod_prime_engine_core_macros.svh"
module bmpe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser
);
  `BMPE_ASSERT_NOW(a_oor_zero, clk, rst, m_tvalid && m_tuser, m_tdata == 32'd0)
  `BMPE_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[31] == 1'b0)
  `BMPE_ASSERT_NEXT(a_busy_after_in, clk, rst, s_tvalid && s_tready, !s_tready)
  `BMPE_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))
endmodule

bind binomial_mod_prime_engine_core bmpe_checker u_bmpe_checker (.*);
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for binomial_mod_prime_engine_core: binomial queries mod a configured modulus,
// checked against an in-bench table predictor. Depends on bmpe_pkg and the engine RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import bmpe_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             oor;
  } binom_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [11:0] total_n, [24:12] choose_r
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [30:0] binomial_value
  logic        m_tuser;         // [0] out_of_range
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  binomial_mod_prime_engine_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [VAL_W-1:0] mod_reg;
  logic [N_W-1:0]   limit_reg;
  longint unsigned  fact_tab[MAX_ENTRIES_DEF];
  longint unsigned  inv_tab[MAX_ENTRIES_DEF];
  longint unsigned  ifact_tab[MAX_ENTRIES_DEF];
  bit               tabs_built;

  binom_result_t expected_q[$];
  int            mismatches = 0;
  int            send_idle = 0;
  int            recv_idle = 0;
  bit            stall_request = 0;
  int            stall_left = 0;
  longint unsigned cycles = 0;

  function automatic longint unsigned eff_mod();
    return (mod_reg == 0) ? 64'd1 : 64'(mod_reg);
  endfunction

  function automatic void build_tabs();
    longint unsigned m, q, rem, t, iv;
    m = eff_mod();
    fact_tab[0] = 1 % m;
    inv_tab[0] = 0;
    ifact_tab[0] = 1 % m;
    if (limit_reg >= 1) begin
      fact_tab[1] = 1 % m;
      inv_tab[1] = 1 % m;
      ifact_tab[1] = 1 % m;
    end
    for (int i = 2; i <= limit_reg; i++) begin
      q = m / i;
      rem = m % i;
      t = (q * inv_tab[rem]) % m;
      iv = (m - t) % m;
      inv_tab[i] = iv;
      fact_tab[i] = (fact_tab[i-1] * i) % m;
      ifact_tab[i] = (ifact_tab[i-1] * iv) % m;
    end
    tabs_built = 1;
  endfunction

  function automatic binom_result_t predict_binomial(logic [N_W-1:0] n, logic [R_W-1:0] r);
    binom_result_t res;
    longint unsigned m, v;
    res = '0;
    if (!tabs_built) build_tabs();
    m = eff_mod();
    if (n > limit_reg) begin
      res.oor = 1'b1;
    end else if (!r[R_W-1] && r <= n) begin
      v = (fact_tab[n] * ifact_tab[r]) % m;
      v = (v * ifact_tab[n - r]) % m;
      res.value = v[VAL_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver readiness with random idling and a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_request) begin
      stall_request = 0;
      stall_left <= 400;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    binom_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: value %0d oor %0d", m_tdata[VAL_W-1:0], m_tuser);
      end else begin
        exp_res = expected_q.pop_front();
        if (m_tdata[VAL_W-1:0] !== exp_res.value || m_tuser !== exp_res.oor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d oor %0d, got value %0d oor %0d",
                     exp_res.value, exp_res.oor, m_tdata[VAL_W-1:0], m_tuser);
        end
      end
    end
  end

  task automatic send_query(logic [N_W-1:0] n, logic [R_W-1:0] r);
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, r, n};
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(predict_binomial(n, r));
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_MODULUS) mod_reg = data[VAL_W-1:0];
    else limit_reg = data[N_W-1:0];
    tabs_built = 0;
  endtask

  task automatic configure(logic [30:0] m, logic [11:0] lim);
    reg_write(3'd4 * REG_MODULUS, {1'b0, m});
    reg_write(3'd4 * REG_LIMIT, {20'd0, lim});
  endtask

  task automatic random_query(int lim);
    logic [N_W-1:0] n;
    logic [R_W-1:0] r;
    n = ($urandom_range(9) == 0) ? N_W'($urandom) : N_W'($urandom_range(0, lim + 3));
    r = ($urandom_range(7) == 0) ? R_W'($urandom) : R_W'($urandom_range(0, n));
    send_query(n, r);
  endtask

  task automatic test_directed();
    configure(31'd1000000007, 12'd40);
    send_query(12'd0, 13'd0);
    send_query(12'd40, 13'd20);
    send_query(12'd40, 13'd40);
    send_query(12'd40, 13'd41);
    send_query(12'd40, -13'sd1);
    send_query(12'd40, 13'h0FFF);
    send_query(12'd41, 13'd0);
    send_query(12'hFFF, 13'h1000);
    send_query(12'd0, 13'h1000);
    send_query(12'd17, 13'd5);
    configure(31'd7, 12'd30);
    send_query(12'd30, 13'd12);
    send_query(12'd13, 13'd6);
    configure(31'd0, 12'd5);
    send_query(12'd5, 13'd2);
    configure(31'd2, 12'd0);
    send_query(12'd0, 13'd0);
    send_query(12'd1, 13'd0);
    send_query(12'd0, 13'd1);
    configure(31'h7FFFFFFF, 12'd60);
    send_query(12'd60, 13'd30);
    send_query(12'd59, 13'd1);
  endtask

  task automatic test_random_phase();
    int lim;
    logic [30:0] m;
    for (int blk = 0; blk < 5; blk++) begin
      lim = ($urandom_range(3) == 0) ? $urandom_range(0, 12) : $urandom_range(13, 200);
      case ($urandom_range(3))
        0: m = 31'd1000000007;
        1: m = 31'($urandom_range(2, 50));
        2: m = 31'd998244353;
        default: m = 31'($urandom_range(2, 32'h7FFFFFFF));
      endcase
      configure(m, 12'(lim));
      repeat (100) random_query(lim);
    end
  endtask

  task automatic test_backpressure();
    configure(31'd1000000007, 12'd100);
    send_query(12'd3, 13'd1);
    stall_request = 1;
    repeat (30) random_query(100);
  endtask

  task automatic test_pause();
    repeat (6) random_query(100);
    drain();
    repeat (6) random_query(100);
  endtask

  task automatic test_full_table();
    configure(31'd1000000007, 12'd4095);
    send_query(12'd4095, 13'd2047);
    send_query(12'd4095, 13'd4095);
    send_query(12'd4095, 13'd0);
    send_query(12'd4094, 13'h0FFF);
    repeat (10) random_query(4092);
  endtask

  initial begin
    mod_reg = MOD_RESET;
    limit_reg = LIMIT_RESET;
    tabs_built = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle = 38;
    recv_idle = 45;
    test_random_phase();
    test_backpressure();
    send_idle = 45;
    recv_idle = 38;
    test_random_phase();
    test_pause();
    send_idle = 0;
    recv_idle = 0;
    test_random_phase();
    test_full_table();
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bmpe_pkg.sv
hw/rtl/bmpe_ram.sv
hw/rtl/bmpe_mulmod.sv
hw/rtl/bmpe_divmod.sv
hw/rtl/binomial_mod_prime_engine_core.sv
hw/rtl/bmpe_checker.sv
tb/tb_top.sv
